@@ hdl/lake_phosphorus_objective_sim_defines.svh @@
// Assertion helpers used by the checker.
`ifndef LAKE_PHOSPHORUS_OBJECTIVE_SIM_DEFINES_SVH
`define LAKE_PHOSPHORUS_OBJECTIVE_SIM_DEFINES_SVH

// Checked out of reset only.
`define LPO_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define LPO_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ hdl/lpo_pkg.sv @@
`timescale 1ns / 1ps
package lpo_pkg;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_M_POL,
    ST_D_POL,
    ST_M_LDR,
    ST_D_LDR,
    ST_M_T1,
    ST_M_SQ,
    ST_D_T2,
    ST_M_GAIN,
    ST_M_COST,
    ST_M_DT,
    ST_M_DF,
    ST_D_MOD,
    ST_D_PCT,
    ST_NEXT,
    ST_D_MLV,
    ST_D_REL,
    ST_D_MLD,
    ST_D_LATE,
    ST_EMIT
  } lpo_state_e;

  typedef enum logic [2:0] {
    REG_RETENTION = 3'd0,
    REG_GAIN      = 3'd1,
    REG_DAMAGE    = 3'd2,
    REG_DISCOUNT  = 3'd3,
    REG_CRITICAL  = 3'd4,
    REG_INITIAL   = 3'd5,
    REG_YPD       = 3'd6
  } lpo_reg_e;

  localparam int unsigned MUL_A_W   = 64;
  localparam int unsigned MUL_B_W   = 32;
  localparam int unsigned MUL_DIG_W = 4;
  localparam int unsigned DIV_W     = 64;
  localparam int unsigned DIV_CNT_W = 7;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] iters;
  } lpo_div_req_t;

  // Quotient bit counts per division, bounded over the parameter ranges.
  localparam int unsigned DEC_IT  = 51;
  localparam int unsigned T2_IT   = 58;
  localparam int unsigned MOD_IT  = 7;
  localparam int unsigned PCT_IT  = 44;
  localparam int unsigned SUM_IT  = 36;
  localparam int unsigned REL_IT  = 24;
  localparam int unsigned LATE_IT = 47;

  localparam logic [27:0] M28 = 28'hFFFFFFF;
  localparam logic [34:0] M35 = 35'h7FFFFFFFF;
  localparam logic [23:0] M24 = 24'hFFFFFF;

  localparam logic signed [63:0] U40_HI = 64'sh0000_007F_FFFF_FFFF;
  localparam logic signed [63:0] U40_LO = 64'shFFFF_FF80_0000_0000;
  localparam logic signed [63:0] L46_HI = 64'sh0000_1FFF_FFFF_FFFF;
  localparam logic signed [63:0] L46_LO = 64'shFFFF_E000_0000_0000;

  localparam logic [15:0] RST_RETENTION = 16'd27525;
  localparam logic [15:0] RST_GAIN      = 16'd26214;
  localparam logic [15:0] RST_DAMAGE    = 16'd5243;
  localparam logic [15:0] RST_DISCOUNT  = 16'd64225;
  localparam logic [27:0] RST_CRITICAL  = 28'd524288;
  localparam logic [27:0] RST_INITIAL   = 28'd0;
  localparam logic [6:0]  RST_YPD       = 7'd5;
  localparam logic [16:0] DF_ONE        = 17'h10000;

  function automatic longint unsigned pow10(input int unsigned d);
    longint unsigned p;
    p = 1;
    for (int k = 0; k < 6; k++) begin
      if (k < d) p = p * 10;
    end
    return p;
  endfunction

endpackage

@@ hdl/lake_phosphorus_objective_sim.sv @@
`timescale 1ns / 1ps
// Shallow lake phosphorus objective simulator.
// Input channel (in_valid_i/in_ready_o) takes one simulated year per
// transaction: human load, natural inflow and a last-year mark. The output
// channel (out_valid_o/out_ready_i) carries one transaction of run objectives
// after the year marked last; other years give no output.
// Configuration registers are written through cfg_we_i/cfg_addr_i/cfg_wdata_i;
// the user must write them only while no year is in flight; the block does not check.
// Each year passes a sequencer over one shared digit-serial multiplier (four
// bits a cycle) and one shared restoring divider (one quotient bit a cycle).
// A year runs eight products and four divisions, two of them rounding
// divisions of the loads, and one more division on a decision boundary. The
// last year adds up to four divisions for the means. in_ready_o is high only
// when the sequencer is idle.
// Reset restores the register defaults, clears the run and drops out_valid_o.
// While the receiver stalls the result stays held; years keep being taken,
// and a following last year waits before its result is loaded.
module lake_phosphorus_objective_sim #(
  parameter int unsigned YEARS        = 100,
  parameter int unsigned ROUND_DIGITS = 3,
  parameter int unsigned FRAC_BITS    = 20
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_addr_i,
  input  logic [27:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [27:0]        human_load_i,
  input  logic [27:0]        natural_inflow_i,
  input  logic               last_year_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [27:0]        mean_level_o,
  output logic signed [39:0] discounted_utility_o,
  output logic signed [39:0] first_utility_o,
  output logic signed [39:0] late_mean_utility_o,
  output logic [16:0]        reliability_o,
  output logic [27:0]        mean_load_o,
  output logic [23:0]        max_inertia_o,
  output logic               saturated_o
);

  localparam logic [7:0]  HalfYears = 8'(YEARS / 2);
  localparam logic [63:0] P10       = 64'(lpo_pkg::pow10(ROUND_DIGITS));
  localparam logic [63:0] P10Half   = P10 >> 1;
  localparam logic [63:0] FbOne     = 64'(1) << FRAC_BITS;
  localparam logic [63:0] FbHalf    = 64'(1) << (FRAC_BITS - 1);
  localparam logic [63:0] RndQ16    = 64'd32768;

  lpo_pkg::lpo_state_e state_q, state_d;
  logic launched_q, launched_d;

  logic [15:0] ret_q, ug_q, dc_q, dr_q;
  logic [27:0] crit_q, init_q;
  logic [6:0]  ypd_q;

  logic [6:0]         year_q, rc_q;
  logic [27:0]        lake_q, prev_q;
  logic [34:0]        lsum_q, dsum_q;
  logic [16:0]        df_q;
  logic signed [39:0] usum_q, first_q;
  logic signed [45:0] late_q;
  logic [23:0]        imax_q;
  logic               sat_q;
  logic               out_valid_q;

  logic [27:0]        ld_q, nat_q, x_q, pol_q, ldr_q, gain_q;
  logic               last_q;
  logic [49:0]        tmp_q;
  logic [28:0]        t1_q;
  logic [45:0]        sq_q;
  logic signed [39:0] u_q;
  logic [27:0]        mlv_q, mld_q;
  logic [16:0]        rel_q;
  logic [39:0]        lateo_q;

  logic [27:0]        mean_level_q, mean_load_q;
  logic signed [39:0] dutil_q, futil_q, lutil_q;
  logic [16:0]        rel_out_q;
  logic [23:0]        imax_out_q;
  logic               sat_out_q;

  logic        mul_start, mul_done;
  logic [63:0] mul_a, mul_res;
  logic [31:0] mul_b;
  lpo_pkg::lpo_div_req_t div_req;
  logic        div_done;
  logic [63:0] div_num, div_den, div_quo, div_rem;

  logic is_mul, is_div, unit_done, step_done, accept, emit;
  logic [7:0]  n_w, lc_w;
  logic [6:0]  ypd_eff;
  logic [63:0] dec_num, t2_den, t2_num, pct_num, cost, xsum, late_mag_sum;
  logic [27:0] ld_diff, xn, q28;
  logic        q28_sat;
  logic [45:0] late_mag;
  logic signed [63:0] udiff, dt, usum_new, late_new;

  lpo_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_res)
  );

  lpo_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo),
    .rem_o  (div_rem)
  );

  // datapath terms
  always_comb begin
    n_w      = {1'b0, year_q} + 8'd1;
    lc_w     = (n_w > HalfYears) ? n_w - HalfYears : 8'd0;
    ypd_eff  = (ypd_q == 7'd0) ? 7'd1 : ypd_q;
    dec_num  = (((64'(tmp_q) + FbHalf) >> FRAC_BITS) << FRAC_BITS) + P10Half;
    t2_den   = FbOne + 64'(sq_q);
    t2_num   = (64'(sq_q) << FRAC_BITS) + (t2_den >> 1);
    ld_diff  = (ld_q > prev_q) ? ld_q - prev_q : prev_q - ld_q;
    pct_num  = (64'(ld_diff) << 14) + (64'(ld_diff) << 13) + (64'(ld_diff) << 10)
             + 64'(prev_q >> 1);
    late_mag = late_q[45] ? 46'(-late_q) : 46'(late_q);
    late_mag_sum = 64'(late_mag) + 64'(lc_w >> 1);
    q28_sat  = div_quo > 64'(lpo_pkg::M28);
    q28      = q28_sat ? lpo_pkg::M28 : div_quo[27:0];
    xsum     = 64'(t1_q) + div_quo + 64'(pol_q);
    xn       = (xsum > 64'(lpo_pkg::M28)) ? lpo_pkg::M28 : xsum[27:0];
    cost     = (mul_res + RndQ16) >> 16;
    udiff    = $signed({36'd0, gain_q}) - $signed(cost);
    dt       = $signed(mul_res + RndQ16) >>> 16;
    usum_new = $signed({{24{usum_q[39]}}, usum_q}) + dt;
    late_new = $signed({{18{late_q[45]}}, late_q}) + $signed({{24{u_q[39]}}, u_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= lpo_pkg::ST_IDLE;
      launched_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      launched_q <= launched_d;
    end
  end

  always_comb begin
    is_mul = state_q inside {lpo_pkg::ST_M_POL, lpo_pkg::ST_M_LDR, lpo_pkg::ST_M_T1,
                             lpo_pkg::ST_M_SQ, lpo_pkg::ST_M_GAIN, lpo_pkg::ST_M_COST,
                             lpo_pkg::ST_M_DT, lpo_pkg::ST_M_DF};
    is_div = state_q inside {lpo_pkg::ST_D_POL, lpo_pkg::ST_D_LDR, lpo_pkg::ST_D_T2,
                             lpo_pkg::ST_D_MOD, lpo_pkg::ST_D_PCT, lpo_pkg::ST_D_MLV,
                             lpo_pkg::ST_D_REL, lpo_pkg::ST_D_MLD, lpo_pkg::ST_D_LATE};
    unit_done  = is_mul ? mul_done : div_done;
    step_done  = launched_q && unit_done;
    mul_start  = is_mul && !launched_q;
    div_req.start = is_div && !launched_q;
    launched_d = (is_mul || is_div) && !step_done;
    in_ready_o = (state_q == lpo_pkg::ST_IDLE);
    accept     = in_valid_i && in_ready_o;
    emit       = (state_q == lpo_pkg::ST_EMIT) && (!out_valid_q || out_ready_i);

    mul_a         = '0;
    mul_b         = '0;
    div_num       = '0;
    div_den       = 64'd1;
    div_req.iters = 7'd1;
    state_d       = state_q;

    case (state_q)
      lpo_pkg::ST_IDLE: if (accept) state_d = lpo_pkg::ST_M_POL;
      lpo_pkg::ST_M_POL: begin
        mul_a = 64'(ld_q) + 64'(nat_q);
        mul_b = P10[31:0];
        if (step_done) state_d = lpo_pkg::ST_D_POL;
      end
      lpo_pkg::ST_D_POL, lpo_pkg::ST_D_LDR: begin
        div_num       = dec_num << (64 - lpo_pkg::DEC_IT);
        div_den       = P10;
        div_req.iters = 7'(lpo_pkg::DEC_IT);
        if (step_done) begin
          state_d = (state_q == lpo_pkg::ST_D_POL) ? lpo_pkg::ST_M_LDR : lpo_pkg::ST_M_T1;
        end
      end
      lpo_pkg::ST_M_LDR: begin
        mul_a = 64'(ld_q);
        mul_b = P10[31:0];
        if (step_done) state_d = lpo_pkg::ST_D_LDR;
      end
      lpo_pkg::ST_M_T1: begin
        mul_a = 64'(x_q);
        mul_b = 32'(lpo_pkg::DF_ONE - {1'b0, ret_q});
        if (step_done) state_d = lpo_pkg::ST_M_SQ;
      end
      lpo_pkg::ST_M_SQ: begin
        mul_a = 64'(x_q);
        mul_b = 32'(x_q);
        if (step_done) state_d = lpo_pkg::ST_D_T2;
      end
      lpo_pkg::ST_D_T2: begin
        div_num       = t2_num << (64 - lpo_pkg::T2_IT);
        div_den       = t2_den;
        div_req.iters = 7'(lpo_pkg::T2_IT);
        if (step_done) state_d = lpo_pkg::ST_M_GAIN;
      end
      lpo_pkg::ST_M_GAIN: begin
        mul_a = 64'(ldr_q);
        mul_b = 32'(ug_q);
        if (step_done) state_d = lpo_pkg::ST_M_COST;
      end
      lpo_pkg::ST_M_COST: begin
        mul_a = 64'(sq_q);
        mul_b = 32'(dc_q);
        if (step_done) state_d = lpo_pkg::ST_M_DT;
      end
      lpo_pkg::ST_M_DT: begin
        mul_a = {{24{u_q[39]}}, u_q};
        mul_b = 32'(df_q);
        if (step_done) state_d = lpo_pkg::ST_M_DF;
      end
      lpo_pkg::ST_M_DF: begin
        mul_a = 64'(df_q);
        mul_b = 32'(dr_q);
        if (step_done) state_d = lpo_pkg::ST_D_MOD;
      end
      lpo_pkg::ST_D_MOD: begin
        div_num       = 64'(year_q) << (64 - lpo_pkg::MOD_IT);
        div_den       = 64'(ypd_eff);
        div_req.iters = 7'(lpo_pkg::MOD_IT);
        if (step_done) begin
          if (div_rem == '0 && year_q != 7'd0 && prev_q != 28'd0) begin
            state_d = lpo_pkg::ST_D_PCT;
          end else begin
            state_d = lpo_pkg::ST_NEXT;
          end
        end
      end
      lpo_pkg::ST_D_PCT: begin
        div_num       = pct_num << (64 - lpo_pkg::PCT_IT);
        div_den       = 64'(prev_q);
        div_req.iters = 7'(lpo_pkg::PCT_IT);
        if (step_done) state_d = lpo_pkg::ST_NEXT;
      end
      lpo_pkg::ST_NEXT: state_d = last_q ? lpo_pkg::ST_D_MLV : lpo_pkg::ST_IDLE;
      lpo_pkg::ST_D_MLV: begin
        div_num       = (64'(lsum_q) + 64'(n_w >> 1)) << (64 - lpo_pkg::SUM_IT);
        div_den       = 64'(n_w);
        div_req.iters = 7'(lpo_pkg::SUM_IT);
        if (step_done) state_d = lpo_pkg::ST_D_REL;
      end
      lpo_pkg::ST_D_REL: begin
        div_num       = ((64'(rc_q) << 16) + 64'(n_w >> 1)) << (64 - lpo_pkg::REL_IT);
        div_den       = 64'(n_w);
        div_req.iters = 7'(lpo_pkg::REL_IT);
        if (step_done) state_d = lpo_pkg::ST_D_MLD;
      end
      lpo_pkg::ST_D_MLD: begin
        div_num       = (64'(dsum_q) + 64'(n_w >> 1)) << (64 - lpo_pkg::SUM_IT);
        div_den       = 64'(n_w);
        div_req.iters = 7'(lpo_pkg::SUM_IT);
        if (step_done) begin
          state_d = (lc_w != 8'd0) ? lpo_pkg::ST_D_LATE : lpo_pkg::ST_EMIT;
        end
      end
      lpo_pkg::ST_D_LATE: begin
        div_num       = late_mag_sum << (64 - lpo_pkg::LATE_IT);
        div_den       = 64'(lc_w);
        div_req.iters = 7'(lpo_pkg::LATE_IT);
        if (step_done) state_d = lpo_pkg::ST_EMIT;
      end
      lpo_pkg::ST_EMIT: if (emit) state_d = lpo_pkg::ST_IDLE;
      default: state_d = lpo_pkg::ST_IDLE;
    endcase
  end

  // configuration and run state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ret_q       <= lpo_pkg::RST_RETENTION;
      ug_q        <= lpo_pkg::RST_GAIN;
      dc_q        <= lpo_pkg::RST_DAMAGE;
      dr_q        <= lpo_pkg::RST_DISCOUNT;
      crit_q      <= lpo_pkg::RST_CRITICAL;
      init_q      <= lpo_pkg::RST_INITIAL;
      ypd_q       <= lpo_pkg::RST_YPD;
      year_q      <= '0;
      lake_q      <= '0;
      prev_q      <= '0;
      lsum_q      <= '0;
      df_q        <= lpo_pkg::DF_ONE;
      usum_q      <= '0;
      first_q     <= '0;
      late_q      <= '0;
      rc_q        <= '0;
      dsum_q      <= '0;
      imax_q      <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (lpo_pkg::lpo_reg_e'(cfg_addr_i))
          lpo_pkg::REG_RETENTION: ret_q  <= cfg_wdata_i[15:0];
          lpo_pkg::REG_GAIN:      ug_q   <= cfg_wdata_i[15:0];
          lpo_pkg::REG_DAMAGE:    dc_q   <= cfg_wdata_i[15:0];
          lpo_pkg::REG_DISCOUNT:  dr_q   <= cfg_wdata_i[15:0];
          lpo_pkg::REG_CRITICAL:  crit_q <= cfg_wdata_i;
          lpo_pkg::REG_INITIAL:   init_q <= cfg_wdata_i;
          lpo_pkg::REG_YPD:       ypd_q  <= cfg_wdata_i[6:0];
          default: ;
        endcase
      end

      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (step_done) begin
        case (state_q)
          lpo_pkg::ST_D_POL: if (q28_sat) sat_q <= 1'b1;
          lpo_pkg::ST_D_LDR: begin
            if (q28_sat) sat_q <= 1'b1;
            if (36'(dsum_q) + 36'(q28) > 36'(lpo_pkg::M35)) begin
              dsum_q <= lpo_pkg::M35;
              sat_q  <= 1'b1;
            end else begin
              dsum_q <= dsum_q + 35'(q28);
            end
          end
          lpo_pkg::ST_D_T2: begin
            lake_q <= xn;
            if (xsum > 64'(lpo_pkg::M28)) sat_q <= 1'b1;
            if (36'(lsum_q) + 36'(xn) > 36'(lpo_pkg::M35)) begin
              lsum_q <= lpo_pkg::M35;
              sat_q  <= 1'b1;
            end else begin
              lsum_q <= lsum_q + 35'(xn);
            end
            if (xn < crit_q) begin
              if (rc_q < 7'd127) rc_q <= rc_q + 7'd1;
              else sat_q <= 1'b1;
            end
          end
          lpo_pkg::ST_M_COST: begin
            if (udiff > lpo_pkg::U40_HI || udiff < lpo_pkg::U40_LO) sat_q <= 1'b1;
          end
          lpo_pkg::ST_M_DT: begin
            if (year_q == 7'd0) first_q <= u_q;
            if ({1'b0, year_q} >= HalfYears) begin
              if (late_new > lpo_pkg::L46_HI) begin
                late_q <= 46'(lpo_pkg::L46_HI);
                sat_q  <= 1'b1;
              end else if (late_new < lpo_pkg::L46_LO) begin
                late_q <= 46'(lpo_pkg::L46_LO);
                sat_q  <= 1'b1;
              end else begin
                late_q <= 46'(late_new);
              end
            end
            if (usum_new > lpo_pkg::U40_HI) begin
              usum_q <= 40'(lpo_pkg::U40_HI);
              sat_q  <= 1'b1;
            end else if (usum_new < lpo_pkg::U40_LO) begin
              usum_q <= 40'(lpo_pkg::U40_LO);
              sat_q  <= 1'b1;
            end else begin
              usum_q <= 40'(usum_new);
            end
          end
          lpo_pkg::ST_M_DF: df_q <= 17'((mul_res + RndQ16) >> 16);
          lpo_pkg::ST_D_MOD: begin
            if (div_rem == '0) begin
              if (year_q == 7'd0) begin
                prev_q <= ld_q;
              end else if (prev_q == 28'd0) begin
                imax_q <= lpo_pkg::M24;
                sat_q  <= 1'b1;
                prev_q <= ld_q;
              end
            end
          end
          lpo_pkg::ST_D_PCT: begin
            if (div_quo > 64'(lpo_pkg::M24)) begin
              imax_q <= lpo_pkg::M24;
              sat_q  <= 1'b1;
            end else if (div_quo[23:0] > imax_q) begin
              imax_q <= div_quo[23:0];
            end
            prev_q <= ld_q;
          end
          lpo_pkg::ST_D_MLD: if (lc_w == 8'd0) sat_q <= 1'b1;
          default: ;
        endcase
      end

      if (state_q == lpo_pkg::ST_NEXT && !last_q) begin
        if (year_q < 7'd127) year_q <= year_q + 7'd1;
        else sat_q <= 1'b1;
      end

      // drop the run once its result is loaded
      if (emit) begin
        year_q  <= '0;
        lake_q  <= '0;
        prev_q  <= '0;
        lsum_q  <= '0;
        df_q    <= lpo_pkg::DF_ONE;
        usum_q  <= '0;
        first_q <= '0;
        late_q  <= '0;
        rc_q    <= '0;
        dsum_q  <= '0;
        imax_q  <= '0;
        sat_q   <= 1'b0;
      end
    end
  end

  // working and result registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ld_q   <= human_load_i;
      nat_q  <= natural_inflow_i;
      last_q <= last_year_i;
      x_q    <= (year_q == 7'd0) ? init_q : lake_q;
    end
    if (step_done) begin
      case (state_q)
        lpo_pkg::ST_M_POL, lpo_pkg::ST_M_LDR: tmp_q <= mul_res[49:0];
        lpo_pkg::ST_D_POL:  pol_q  <= q28;
        lpo_pkg::ST_D_LDR:  ldr_q  <= q28;
        lpo_pkg::ST_M_T1:   t1_q   <= 29'((mul_res + RndQ16) >> 16);
        lpo_pkg::ST_M_SQ:   sq_q   <= 46'((mul_res + FbHalf) >> FRAC_BITS);
        lpo_pkg::ST_M_GAIN: gain_q <= 28'((mul_res + RndQ16) >> 16);
        lpo_pkg::ST_M_COST: begin
          if (udiff > lpo_pkg::U40_HI) u_q <= 40'(lpo_pkg::U40_HI);
          else if (udiff < lpo_pkg::U40_LO) u_q <= 40'(lpo_pkg::U40_LO);
          else u_q <= 40'(udiff);
        end
        lpo_pkg::ST_D_MLV:  mlv_q <= div_quo[27:0];
        lpo_pkg::ST_D_REL:  rel_q <= div_quo[16:0];
        lpo_pkg::ST_D_MLD: begin
          mld_q   <= div_quo[27:0];
          lateo_q <= '0;
        end
        lpo_pkg::ST_D_LATE: lateo_q <= late_q[45] ? 40'(-div_quo) : div_quo[39:0];
        default: ;
      endcase
    end
    if (emit) begin
      mean_level_q <= mlv_q;
      dutil_q      <= usum_q;
      futil_q      <= first_q;
      lutil_q      <= lateo_q;
      rel_out_q    <= rel_q;
      mean_load_q  <= mld_q;
      imax_out_q   <= imax_q;
      sat_out_q    <= sat_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign mean_level_o         = mean_level_q;
  assign discounted_utility_o = dutil_q;
  assign first_utility_o      = futil_q;
  assign late_mean_utility_o  = lutil_q;
  assign reliability_o        = rel_out_q;
  assign mean_load_o          = mean_load_q;
  assign max_inertia_o        = imax_out_q;
  assign saturated_o          = sat_out_q;

endmodule

@@ hdl/lpo_mul.sv @@
`timescale 1ns / 1ps
module lpo_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [lpo_pkg::MUL_A_W-1:0] a_i,
  input  logic [lpo_pkg::MUL_B_W-1:0] b_i,
  output logic                        done_o,
  output logic [lpo_pkg::MUL_A_W-1:0] prod_o
);

  localparam int unsigned Steps = lpo_pkg::MUL_B_W / lpo_pkg::MUL_DIG_W;
  localparam int unsigned CntW  = $clog2(Steps);

  logic [lpo_pkg::MUL_A_W-1:0] a_q, acc_q, acc_d, part;
  logic [lpo_pkg::MUL_B_W-1:0] b_q;
  logic [CntW-1:0]             cnt_q;
  logic                        busy_q, done_q;

  always_comb begin
    part  = a_q * lpo_pkg::MUL_A_W'(b_q[lpo_pkg::MUL_DIG_W-1:0]);
    acc_d = acc_q + part;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(Steps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // advance one digit of b per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_d;
      a_q   <= a_q << lpo_pkg::MUL_DIG_W;
      b_q   <= b_q >> lpo_pkg::MUL_DIG_W;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

@@ hdl/lpo_div.sv @@
`timescale 1ns / 1ps
module lpo_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lpo_pkg::lpo_div_req_t     req_i,
  input  logic [lpo_pkg::DIV_W-1:0] num_i,
  input  logic [lpo_pkg::DIV_W-1:0] den_i,
  output logic                      done_o,
  output logic [lpo_pkg::DIV_W-1:0] quo_o,
  output logic [lpo_pkg::DIV_W-1:0] rem_o
);

  localparam int unsigned W = lpo_pkg::DIV_W;

  logic [W-1:0]                  num_q, den_q, rem_q, rem_d;
  logic [W:0]                    trial, diff;
  logic                          ge;
  logic [lpo_pkg::DIV_CNT_W-1:0] cnt_q, iters_q;
  logic                          busy_q, done_q;

  always_comb begin
    trial = {rem_q, num_q[W-1]};
    diff  = trial - {1'b0, den_q};
    ge    = trial >= {1'b0, den_q};
    rem_d = ge ? diff[W-1:0] : trial[W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == iters_q - 1'b1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q   <= num_i;
      den_q   <= den_i;
      rem_q   <= '0;
      iters_q <= req_i.iters;
    end else if (busy_q) begin
      rem_q <= rem_d;
      num_q <= {num_q[W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;
  assign rem_o  = rem_q;

endmodule

@@ hdl/lpo_checker.sv @@
`timescale 1ns / 1ps
`include "lake_phosphorus_objective_sim_defines.svh"
module lpo_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [27:0] mean_level_o,
  input logic [16:0] reliability_o
);

  `LPO_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(mean_level_o), "result dropped or changed while stalled")
  `LPO_ASSERT(a_one_year, in_valid_i && in_ready_o |=> !in_ready_o, "year taken while another is in work")
  `LPO_ASSERT(a_rel_range, out_valid_o |-> reliability_o <= 17'd65536, "reliability above one")
  `LPO_ASSERT_RST(a_reset, !rst_ni |-> !out_valid_o && in_ready_o, "reset state wrong")

endmodule

bind lake_phosphorus_objective_sim lpo_checker u_lpo_checker (.*);

@@ sim/lake_phosphorus_objective_sim_test.sv @@
`timescale 1ns / 1ps
module lake_phosphorus_objective_sim_test;

  localparam int unsigned  YEARS     = 100;
  localparam int unsigned  HALF      = YEARS / 2;
  localparam logic [63:0]  DEC_SCALE = 64'd1000;
  localparam int unsigned  FRAC      = 20;
  localparam int unsigned  SETTLE    = 800;
  localparam longint       LIMIT     = 6000000;

  typedef struct {
    logic [27:0]        mean_level;
    logic signed [39:0] discounted_utility;
    logic signed [39:0] first_utility;
    logic signed [39:0] late_mean_utility;
    logic [16:0]        reliability;
    logic [27:0]        mean_load;
    logic [23:0]        max_inertia;
    logic               saturated;
  } objectives_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [2:0] cfg_addr_i;
  logic [27:0] cfg_wdata_i;
  logic in_valid_i;
  logic in_ready_o;
  logic [27:0] human_load_i;
  logic [27:0] natural_inflow_i;
  logic last_year_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [27:0] mean_level_o;
  logic signed [39:0] discounted_utility_o;
  logic signed [39:0] first_utility_o;
  logic signed [39:0] late_mean_utility_o;
  logic [16:0] reliability_o;
  logic [27:0] mean_load_o;
  logic [23:0] max_inertia_o;
  logic saturated_o;

  lake_phosphorus_objective_sim dut (.*);

  objectives_t pending_objectives[$];
  int     errors;
  longint cycles;
  int     send_idle_pct;
  int     recv_stall_pct;
  int     hold_left;

  logic [63:0] cfg_loss, cfg_gain, cfg_damage, cfg_disc, cfg_crit, cfg_init, cfg_ypd;
  logic [63:0] yr, lvl, prev_load, lvl_sum, disc_f, rel_cnt, load_sum, inertia;
  longint      util_sum, first_util, late_sum;
  bit          run_sat;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk_i) begin
    objectives_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_objectives.size() == 0) begin
        report("unexpected transaction", 64'd0, 64'd0);
      end else begin
        e = pending_objectives.pop_front();
        if (mean_level_o !== e.mean_level)
          report("mean_level", 64'(mean_level_o), 64'(e.mean_level));
        if (discounted_utility_o !== e.discounted_utility)
          report("discounted_utility", 64'(discounted_utility_o), 64'(e.discounted_utility));
        if (first_utility_o !== e.first_utility)
          report("first_utility", 64'(first_utility_o), 64'(e.first_utility));
        if (late_mean_utility_o !== e.late_mean_utility)
          report("late_mean_utility", 64'(late_mean_utility_o), 64'(e.late_mean_utility));
        if (reliability_o !== e.reliability)
          report("reliability", 64'(reliability_o), 64'(e.reliability));
        if (mean_load_o !== e.mean_load)
          report("mean_load", 64'(mean_load_o), 64'(e.mean_load));
        if (max_inertia_o !== e.max_inertia)
          report("max_inertia", 64'(max_inertia_o), 64'(e.max_inertia));
        if (saturated_o !== e.saturated)
          report("saturated", 64'(saturated_o), 64'(e.saturated));
      end
    end
  end

  function automatic logic [63:0] clip_u(input logic [63:0] v, input logic [63:0] mx);
    if (v > mx) begin
      run_sat = 1'b1;
      return mx;
    end
    return v;
  endfunction

  function automatic longint clip_s(input longint v, input int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      run_sat = 1'b1;
      return hi;
    end
    if (v < lo) begin
      run_sat = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic logic [63:0] round_decimal(input logic [63:0] v);
    logic [63:0] n;
    n = (v * DEC_SCALE + (64'd1 << (FRAC - 1))) >> FRAC;
    return ((n << FRAC) + DEC_SCALE / 2) / DEC_SCALE;
  endfunction

  function automatic void clear_run();
    yr = 0; lvl = 0; prev_load = 0; lvl_sum = 0; disc_f = 64'd65536;
    util_sum = 0; first_util = 0; late_sum = 0; rel_cnt = 0; load_sum = 0;
    inertia = 0; run_sat = 1'b0;
  endfunction

  function automatic void advance_year(input logic [27:0] ld_in, input logic [27:0] nat_in,
                                       input logic last);
    logic [63:0] ld, x, pol, ldr, t1, sq, den, t2, xn, gain, cost, ypd, pct, diff;
    logic [63:0] n, lc, mag, q;
    longint u, dt, late;
    objectives_t e;
    ld   = {36'd0, ld_in};
    x    = (yr == 0) ? cfg_init : lvl;
    pol  = clip_u(round_decimal(ld + {36'd0, nat_in}), {36'd0, lpo_pkg::M28});
    ldr  = clip_u(round_decimal(ld), {36'd0, lpo_pkg::M28});
    t1   = (x * (64'd65536 - cfg_loss) + 64'd32768) >> 16;
    sq   = (x * x + (64'd1 << (FRAC - 1))) >> FRAC;
    den  = (64'd1 << FRAC) + sq;
    t2   = ((sq << FRAC) + den / 2) / den;
    xn   = clip_u(t1 + t2 + pol, {36'd0, lpo_pkg::M28});
    gain = (cfg_gain * ldr + 64'd32768) >> 16;
    cost = (cfg_damage * sq + 64'd32768) >> 16;
    ypd  = (cfg_ypd != 0) ? cfg_ypd : 64'd1;
    lvl  = xn;
    u    = clip_s(longint'(gain) - longint'(cost), 40);
    dt   = (u * longint'(disc_f) + 32768) >>> 16;
    util_sum = clip_s(util_sum + dt, 40);
    disc_f   = (disc_f * cfg_disc + 64'd32768) >> 16;
    if (yr == 0) first_util = u;
    if (yr >= HALF) late_sum = clip_s(late_sum + u, 46);
    if (xn < cfg_crit) begin
      if (rel_cnt < 127) rel_cnt++;
      else run_sat = 1'b1;
    end
    lvl_sum  = clip_u(lvl_sum + xn, {29'd0, lpo_pkg::M35});
    load_sum = clip_u(load_sum + ldr, {29'd0, lpo_pkg::M35});
    if (yr % ypd == 0) begin
      if (yr > 0) begin
        if (prev_load == 0) begin
          pct = {40'd0, lpo_pkg::M24};
          run_sat = 1'b1;
        end else begin
          diff = (ld > prev_load) ? ld - prev_load : prev_load - ld;
          pct  = clip_u((diff * 64'd25600 + prev_load / 2) / prev_load,
                        {40'd0, lpo_pkg::M24});
        end
        if (pct > inertia) inertia = pct;
      end
      prev_load = ld;
    end
    if (!last) begin
      if (yr < 127) yr++;
      else run_sat = 1'b1;
      return;
    end
    n    = yr + 1;
    lc   = (n > HALF) ? n - HALF : 64'd0;
    late = 0;
    if (lc == 0) begin
      run_sat = 1'b1;
    end else begin
      mag  = (late_sum < 0) ? 64'(-late_sum) : 64'(late_sum);
      q    = (mag + lc / 2) / lc;
      late = (late_sum < 0) ? -longint'(q) : longint'(q);
    end
    e.mean_level         = 28'((lvl_sum + n / 2) / n);
    e.discounted_utility = 40'(util_sum);
    e.first_utility      = 40'(first_util);
    e.late_mean_utility  = 40'(late);
    e.reliability        = 17'((rel_cnt * 64'd65536 + n / 2) / n);
    e.mean_load          = 28'((load_sum + n / 2) / n);
    e.max_inertia        = 24'(inertia);
    e.saturated          = run_sat;
    pending_objectives.push_back(e);
    clear_run();
  endfunction

  task automatic offer_year(input logic [27:0] ld, input logic [27:0] nat, input logic last);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    human_load_i     <= ld;
    natural_inflow_i <= nat;
    last_year_i      <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    advance_year(ld, nat, last);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    wait (pending_objectives.size() == 0);
    @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input lpo_pkg::lpo_reg_e idx, input logic [27:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      lpo_pkg::REG_RETENTION: cfg_loss   = {48'd0, val[15:0]};
      lpo_pkg::REG_GAIN:      cfg_gain   = {48'd0, val[15:0]};
      lpo_pkg::REG_DAMAGE:    cfg_damage = {48'd0, val[15:0]};
      lpo_pkg::REG_DISCOUNT:  cfg_disc   = {48'd0, val[15:0]};
      lpo_pkg::REG_CRITICAL:  cfg_crit   = {36'd0, val};
      lpo_pkg::REG_INITIAL:   cfg_init   = {36'd0, val};
      lpo_pkg::REG_YPD:       cfg_ypd    = {57'd0, val[6:0]};
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [15:0] loss, gain, dmg, disc,
                           input logic [27:0] crit, init, input logic [6:0] ypd);
    write_reg(lpo_pkg::REG_RETENTION, {12'd0, loss});
    write_reg(lpo_pkg::REG_GAIN, {12'd0, gain});
    write_reg(lpo_pkg::REG_DAMAGE, {12'd0, dmg});
    write_reg(lpo_pkg::REG_DISCOUNT, {12'd0, disc});
    write_reg(lpo_pkg::REG_CRITICAL, crit);
    write_reg(lpo_pkg::REG_INITIAL, init);
    write_reg(lpo_pkg::REG_YPD, {21'd0, ypd});
  endtask

  function automatic logic [27:0] pick_value(input int kind);
    case (kind)
      0: return 28'($urandom_range(0, 150000));
      1: return 28'($urandom);
      2: return 28'd0;
      default: return lpo_pkg::M28;
    endcase
  endfunction

  task automatic send_run(input int len, input bit wild);
    for (int i = 0; i < len; i++) begin
      if (wild)
        offer_year(pick_value($urandom_range(0, 3)), pick_value($urandom_range(0, 3)),
                   i == len - 1);
      else
        offer_year(pick_value(($urandom_range(0, 19) == 0) ? 2 : 0),
                   28'($urandom_range(0, 60000)), i == len - 1);
    end
  endtask

  task automatic test_directed();
    send_run(1, 0);
    offer_year(lpo_pkg::M28, lpo_pkg::M28, 1'b1);
    offer_year(28'd0, 28'd0, 1'b0);
    offer_year(28'd0, 28'd0, 1'b1);
    for (int i = 0; i < 7; i++) offer_year(28'(i * 30000), 28'd20000, 1'b0);
    offer_year(28'd1, 28'd0, 1'b0);
    offer_year(lpo_pkg::M28, 28'd5, 1'b0);
    offer_year(28'd524, 28'd0, 1'b1);
    send_run(4, 1);
    settle();
  endtask

  task automatic test_late_half();
    send_run(52, 0);
    send_run(YEARS, 0);
    settle();
  endtask

  task automatic test_long_run();
    send_run(131, 0);
    settle();
  endtask

  task automatic test_backpressure();
    hold_left     = 6000;
    send_idle_pct = 0;
    send_run(3, 0);
    send_run(2, 0);
    send_run(4, 1);
    settle();
  endtask

  task automatic test_random(input int items);
    int sent;
    int len;
    int r;
    sent = 0;
    while (sent < items) begin
      r = $urandom_range(0, 99);
      if (r < 70)      len = $urandom_range(1, 12);
      else if (r < 85) len = $urandom_range(HALF, HALF + 15);
      else             len = $urandom_range(1, 4);
      send_run(len, r >= 85);
      sent += len;
    end
    settle();
  endtask

  initial begin
    rst_ni = 1'b1; cfg_we_i = 1'b0; cfg_addr_i = '0; cfg_wdata_i = '0;
    in_valid_i = 1'b0; human_load_i = '0; natural_inflow_i = '0; last_year_i = 1'b0;
    errors = 0; cycles = 0; send_idle_pct = 0; recv_stall_pct = 0; hold_left = 0;
    cfg_loss = 64'(lpo_pkg::RST_RETENTION); cfg_gain = 64'(lpo_pkg::RST_GAIN);
    cfg_damage = 64'(lpo_pkg::RST_DAMAGE); cfg_disc = 64'(lpo_pkg::RST_DISCOUNT);
    cfg_crit = 64'(lpo_pkg::RST_CRITICAL); cfg_init = 64'(lpo_pkg::RST_INITIAL);
    cfg_ypd = 64'(lpo_pkg::RST_YPD);
    clear_run();
    #1 rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_late_half();
    test_backpressure();
    send_idle_pct = 69;
    recv_stall_pct = 0;
    test_random(300);

    write_all(16'd0, 16'd0, 16'd0, 16'd0, 28'd0, 28'd0, 7'd0);
    send_idle_pct = 0;
    recv_stall_pct = 69;
    test_directed();
    test_random(250);

    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, lpo_pkg::M28, lpo_pkg::M28, 7'd127);
    send_idle_pct = 34;
    recv_stall_pct = 34;
    test_directed();
    test_long_run();
    test_random(200);

    write_all(16'd27525, 16'd65535, 16'd100, 16'd65535, 28'd600000, 28'd300000, 7'd100);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random(250);

    for (int p = 0; p < 3; p++) begin
      write_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                28'($urandom), ($urandom_range(0, 1) == 1) ? 28'($urandom_range(0, 2000000))
                                                          : 28'($urandom),
                7'($urandom_range(1, 100)));
      send_idle_pct  = (p == 1) ? 69 : 34;
      recv_stall_pct = (p == 2) ? 69 : 34;
      test_random(220);
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
